// File: rtl/cct_pkg.sv
`default_nettype none

package cct_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int STEP_W      = ADDR_W + 1;
	localparam int WORD_W      = 32;
	localparam int CNT_W       = 12;
	localparam int LOG_W       = 5;
	localparam int DIV_BIT_W   = $clog2(WORD_W);

	localparam logic [WORD_W-1:0] END_OF_CHAIN       = 32'h0FFF_FFF8;
	localparam logic [WORD_W-1:0] FIRST_DATA_CLUSTER = 32'd2;
	localparam logic [WORD_W-1:0] DEPTH_WORD         = WORD_W'(TABLE_DEPTH);
	localparam logic [STEP_W-1:0] WALK_LIMIT         = STEP_W'(TABLE_DEPTH);

	localparam logic [CNT_W-1:0] CFG_COUNT_RST = 12'd4094;
	localparam logic [LOG_W-1:0] CFG_LOG2_RST  = 5'd12;

	typedef enum logic [1:0] {
		REQ_NEXT,
		REQ_SET,
		REQ_FREE,
		REQ_SEEK
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_SEEK_END,
		STAT_NO_ENTRY
	} status_t;

	typedef enum logic {
		CFG_CLUSTER_COUNT,
		CFG_CLUSTER_LOG2
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_LOOKUP_RD,
		ST_FREE_CHK,
		ST_FREE_RD,
		ST_WALK,
		ST_WALK_RD,
		ST_MEAS,
		ST_MEAS_RD,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_FIN
	} ctrl_state_t;

	typedef struct packed {
		logic [CNT_W-1:0] cluster_count;
		logic [LOG_W-1:0] size_log2;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] dividend;
		logic [ADDR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [ADDR_W-1:0] remainder;
	} div_rsp_t;

	typedef struct packed {
		logic              valid;
		logic [WORD_W-1:0] cluster;
		status_t           status;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/cluster_chain_table_engine.sv
`default_nettype none

// Cluster chain link table with a request stream in and a result stream out.
// s_tuser carries the request kind (next lookup, set next, find free, seek);
// each accepted beat gives exactly one m_* beat, in order. Configuration
// writes go through cfg_we/cfg_index/cfg_data; the user must make them only
// while no request is open, and the block itself does not enforce this. After
// reset the table is cleared one entry per cycle: s_tready stays low until
// all TABLE_DEPTH (4096) entries are cleared, config writes are taken
// meanwhile. One request is worked at a time on a single-port table RAM
// with registered read; s_tready is high only while the sequencer is idle.
// A seek longer than TABLE_DEPTH hops first walks TABLE_DEPTH hops,
// measures the loop it is on, reduces the remaining hops with a bit-serial
// remainder and walks the rest. m_tdata is held in an output register;
// while m_tready is low one finished result waits there, the next request
// is still accepted and worked, and it waits to complete until the slot
// frees.
module cluster_chain_table_engine
	import cct_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [95:0] s_tdata,  // cluster[31:0], next_value[63:32], byte_offset[95:64]
	input  wire logic [1:0]  s_tuser,  // req_type[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,  // result_cluster[31:0], status[33:32], zero[39:34]
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [11:0] cfg_data
);

	cfg_t              cfg_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] out_cluster_q;
	status_t           out_status_q;
	logic              out_free;
	result_t           result;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cluster_count <= CFG_COUNT_RST;
			cfg_q.size_log2     <= CFG_LOG2_RST;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_CLUSTER_COUNT: cfg_q.cluster_count <= cfg_data;
				CFG_CLUSTER_LOG2:  cfg_q.size_log2     <= cfg_data[LOG_W-1:0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result.valid) begin
			out_cluster_q <= result.cluster;
			out_status_q  <= result.status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_status_q, out_cluster_q};

	cct_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_req     (req_t'(s_tuser)),
		.in_cluster (s_tdata[31:0]),
		.in_next    (s_tdata[63:32]),
		.in_offset  (s_tdata[95:64]),
		.out_free   (out_free),
		.result     (result),
		.ram_we     (ram_we),
		.ram_addr   (ram_addr),
		.ram_wdata  (ram_wdata),
		.ram_rdata  (ram_rdata),
		.div_req    (div_req),
		.div_rsp    (div_rsp)
	);

	cct_ram #(
		.WIDTH (WORD_W),
		.DEPTH (TABLE_DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	cct_rem_div u_rem_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

`default_nettype wire

// File: rtl/cct_ram.sv
`default_nettype none

module cct_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

// File: rtl/cct_rem_div.sv
`default_nettype none

module cct_rem_div
	import cct_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_BIT_W-1:0] bit_q;
	logic [WORD_W-1:0]    num_q;
	logic [ADDR_W-1:0]    den_q;
	logic [ADDR_W-1:0]    rem_q;
	logic [ADDR_W:0]      trial;
	logic [ADDR_W:0]      diff;

	// one quotient bit per cycle, MSB first
	assign trial = {rem_q, num_q[WORD_W-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				bit_q  <= '0;
			end else if (busy_q) begin
				bit_q <= bit_q + 1'b1;
				if (bit_q == DIV_BIT_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= (trial >= {1'b0, den_q}) ? diff[ADDR_W-1:0] : trial[ADDR_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q;

endmodule

`default_nettype wire

// File: rtl/cct_ctrl.sv
`default_nettype none

module cct_ctrl
	import cct_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire req_t              in_req,
	input  wire logic [WORD_W-1:0] in_cluster,
	input  wire logic [WORD_W-1:0] in_next,
	input  wire logic [WORD_W-1:0] in_offset,
	input  wire logic              out_free,
	output result_t                result,
	output logic                   ram_we,
	output logic [ADDR_W-1:0]      ram_addr,
	output logic [WORD_W-1:0]      ram_wdata,
	input  wire logic [WORD_W-1:0] ram_rdata,
	output div_req_t               div_req,
	input  wire div_rsp_t          div_rsp
);

	ctrl_state_t       state_q, state_d;
	logic [ADDR_W-1:0] clr_q, clr_d;
	req_t              req_q, req_d;
	logic [WORD_W-1:0] cur_q, cur_d;
	logic [WORD_W-1:0] nv_q, nv_d;
	logic [WORD_W-1:0] hops_q, hops_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic [ADDR_W-1:0] anchor_q, anchor_d;
	logic [ADDR_W-1:0] len_q, len_d;
	logic [WORD_W-1:0] res_q, res_d;
	status_t           st_q, st_d;

	logic [WORD_W-1:0] valid_limit;
	logic              link_ok;
	logic [WORD_W-1:0] link;
	logic              in_table;

	// valid clusters are 2 .. count+1
	assign valid_limit = WORD_W'(cfg.cluster_count) + FIRST_DATA_CLUSTER;
	assign link_ok     = (ram_rdata >= FIRST_DATA_CLUSTER) && (ram_rdata < valid_limit);
	assign link        = link_ok ? ram_rdata : END_OF_CHAIN;
	assign in_table    = cur_q < DEPTH_WORD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q    <= req_d;
		cur_q    <= cur_d;
		nv_q     <= nv_d;
		hops_q   <= hops_d;
		step_q   <= step_d;
		anchor_q <= anchor_d;
		len_q    <= len_d;
		res_q    <= res_d;
		st_q     <= st_d;
	end

	always_comb begin
		state_d          = state_q;
		clr_d            = clr_q;
		req_d            = req_q;
		cur_d            = cur_q;
		nv_d             = nv_q;
		hops_d           = hops_q;
		step_d           = step_q;
		anchor_d         = anchor_q;
		len_d            = len_q;
		res_d            = res_q;
		st_d             = st_q;
		in_ready         = 1'b0;
		ram_we           = 1'b0;
		ram_addr         = cur_q[ADDR_W-1:0];
		ram_wdata        = nv_q;
		div_req.start    = 1'b0;
		div_req.dividend = hops_q - WORD_W'(step_q);
		div_req.divisor  = len_q;
		result.valid     = 1'b0;
		result.cluster   = res_q;
		result.status    = st_q;

		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
				clr_d     = clr_q + 1'b1;
				if (clr_q == ADDR_W'(TABLE_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					req_d   = in_req;
					cur_d   = (in_req == REQ_FREE) ? FIRST_DATA_CLUSTER : in_cluster;
					nv_d    = in_next;
					hops_d  = in_offset >> cfg.size_log2;
					step_d  = '0;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (req_q)
					REQ_NEXT: begin
						if (in_table) begin
							state_d = ST_LOOKUP_RD;
						end else begin
							res_d   = END_OF_CHAIN;
							st_d    = STAT_NO_ENTRY;
							state_d = ST_FIN;
						end
					end
					REQ_SET: begin
						res_d = '0;
						if (in_table) begin
							st_d = STAT_OK;
						end else begin
							st_d = STAT_NO_ENTRY;
						end
						ram_we  = in_table;
						state_d = ST_FIN;
					end
					REQ_FREE: state_d = ST_FREE_CHK;
					REQ_SEEK: state_d = ST_WALK;
					default:  state_d = ST_IDLE;
				endcase
			end
			ST_LOOKUP_RD: begin
				res_d   = link;
				st_d    = STAT_OK;
				state_d = ST_FIN;
			end
			ST_FREE_CHK: begin
				if (!in_table || cur_q >= valid_limit) begin
					res_d   = END_OF_CHAIN;
					st_d    = STAT_NO_ENTRY;
					state_d = ST_FIN;
				end else begin
					state_d = ST_FREE_RD;
				end
			end
			ST_FREE_RD: begin
				if (ram_rdata == '0) begin
					res_d   = cur_q;
					st_d    = STAT_OK;
					state_d = ST_FIN;
				end else begin
					cur_d   = cur_q + 1'b1;
					state_d = ST_FREE_CHK;
				end
			end
			ST_WALK: begin
				if (WORD_W'(step_q) == hops_q) begin
					res_d   = cur_q;
					st_d    = STAT_OK;
					state_d = ST_FIN;
				end else if (cur_q == END_OF_CHAIN) begin
					res_d   = '0;
					st_d    = STAT_SEEK_END;
					state_d = ST_FIN;
				end else if (step_q == WALK_LIMIT) begin
					// past the table depth in hops: cur sits on a cycle
					anchor_d = cur_q[ADDR_W-1:0];
					len_d    = '0;
					state_d  = ST_MEAS;
				end else if (!in_table) begin
					cur_d  = END_OF_CHAIN;
					step_d = step_q + 1'b1;
				end else begin
					state_d = ST_WALK_RD;
				end
			end
			ST_WALK_RD: begin
				cur_d   = link;
				step_d  = step_q + 1'b1;
				state_d = ST_WALK;
			end
			ST_MEAS: begin
				state_d = ST_MEAS_RD;
			end
			ST_MEAS_RD: begin
				cur_d = link;
				len_d = len_q + 1'b1;
				if (link == WORD_W'(anchor_q)) begin
					state_d = ST_DIV_START;
				end else begin
					state_d = ST_MEAS;
				end
			end
			ST_DIV_START: begin
				div_req.start = 1'b1;
				state_d       = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					hops_d  = WORD_W'(div_rsp.remainder);
					step_d  = '0;
					state_d = ST_WALK;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					result.valid = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// File: dv/cluster_chain_table_engine_tb.sv
`timescale 1ns / 100ps

module cluster_chain_table_engine_tb
	import cct_pkg::*;
();

	typedef struct {
		logic [31:0] cl;
		status_t     st;
	} reply_t;

	typedef struct {
		req_t        kind;
		logic [31:0] cl;
		logic [31:0] nv;
		logic [31:0] off;
		bit          typed;
		logic [31:0] want_cl;
		status_t     want_st;
	} probe_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata   = '0;
	logic [1:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [39:0] m_tdata;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = 1'b0;
	logic [11:0] cfg_data  = '0;

	logic [31:0] link_mem [TABLE_DEPTH];
	logic [11:0] clusters_cfg;
	logic [4:0]  log2_cfg;
	reply_t      awaited_replies [$];
	reply_t      got_reply;
	int          mismatches;
	int          send_idle_pct;
	int          recv_idle_pct;

	// one hop is 0x1000 bytes under the reset cluster size
	probe_t probes [26] = '{
		'{REQ_NEXT, 32'd2,          32'd0,          32'h0000_0000, 1'b1, END_OF_CHAIN, STAT_OK},
		'{REQ_NEXT, 32'hFFFF_FFFF,  32'd0,          32'h0000_0000, 1'b1, END_OF_CHAIN, STAT_NO_ENTRY},
		'{REQ_NEXT, 32'd4096,       32'd0,          32'h0000_0000, 1'b1, END_OF_CHAIN, STAT_NO_ENTRY},
		'{REQ_FREE, 32'd0,          32'd0,          32'h0000_0000, 1'b1, 32'd2,        STAT_OK},
		'{REQ_SEEK, END_OF_CHAIN,   32'd0,          32'h0000_1000, 1'b1, 32'd0,        STAT_SEEK_END},
		'{REQ_SEEK, 32'hFFFF_FFFF,  32'd0,          32'h0000_0FFF, 1'b1, 32'hFFFF_FFFF, STAT_OK},
		'{REQ_SET,  32'd4096,       32'd5,          32'h0000_0000, 1'b1, 32'd0,        STAT_NO_ENTRY},
		'{REQ_SET,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF, 1'b1, 32'd0,        STAT_NO_ENTRY},
		'{REQ_SET,  32'd2,          32'd3,          32'h0000_0000, 1'b1, 32'd0,        STAT_OK},
		'{REQ_SET,  32'd3,          32'd4,          32'h0000_0000, 1'b1, 32'd0,        STAT_OK},
		'{REQ_SET,  32'd4,          32'd2,          32'h0000_0000, 1'b1, 32'd0,        STAT_OK},
		'{REQ_NEXT, 32'd2,          32'd0,          32'h0000_0000, 1'b1, 32'd3,        STAT_OK},
		'{REQ_FREE, 32'd0,          32'd0,          32'h0000_0000, 1'b1, 32'd5,        STAT_OK},
		'{REQ_SEEK, 32'd2,          32'd0,          32'h0000_2000, 1'b1, 32'd4,        STAT_OK},
		'{REQ_SEEK, 32'd2,          32'd0,          32'hFFFF_FFFF, 1'b0, 32'd0,        STAT_OK},
		'{REQ_SET,  32'd5,          32'hFFFF_FFFF,  32'h0000_0000, 1'b1, 32'd0,        STAT_OK},
		'{REQ_NEXT, 32'd5,          32'd0,          32'h0000_0000, 1'b1, END_OF_CHAIN, STAT_OK},
		'{REQ_SEEK, 32'd5,          32'd0,          32'h0000_3000, 1'b1, 32'd0,        STAT_SEEK_END},
		'{REQ_SEEK, 32'd4095,       32'd0,          32'h0000_1000, 1'b1, END_OF_CHAIN, STAT_OK},
		'{REQ_SEEK, 32'd4096,       32'd0,          32'h0000_2000, 1'b1, 32'd0,        STAT_SEEK_END},
		'{REQ_SET,  32'd0,          END_OF_CHAIN,   32'h0000_0000, 1'b1, 32'd0,        STAT_OK},
		'{REQ_NEXT, 32'd0,          32'd0,          32'h0000_0000, 1'b1, END_OF_CHAIN, STAT_OK},
		'{REQ_SET,  32'd4095,       32'd4095,       32'h0000_0000, 1'b1, 32'd0,        STAT_OK},
		'{REQ_NEXT, 32'd4095,       32'd0,          32'h0000_0000, 1'b1, 32'd4095,     STAT_OK},
		'{REQ_SEEK, 32'd4095,       32'd0,          32'hFFFF_FFFF, 1'b0, 32'd0,        STAT_OK},
		'{REQ_SEEK, 32'd3,          32'd0,          32'h0000_5000, 1'b0, 32'd0,        STAT_OK}
	};

	cluster_chain_table_engine i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#1_000_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic bit in_data_area(input logic [31:0] c);
		return c >= FIRST_DATA_CLUSTER && c < 32'(clusters_cfg) + FIRST_DATA_CLUSTER;
	endfunction

	function automatic logic [31:0] next_link(input logic [31:0] c);
		if (c >= DEPTH_WORD)
			return END_OF_CHAIN;
		return in_data_area(link_mem[c]) ? link_mem[c] : END_OF_CHAIN;
	endfunction

	function automatic reply_t table_response(input req_t kind, input logic [31:0] cl,
			input logic [31:0] nv, input logic [31:0] off);
		reply_t      r;
		int unsigned first_hop [int unsigned];
		logic [31:0] hops, pos, k, left;
		r.cl = '0;
		r.st = STAT_OK;
		case (kind)
			REQ_NEXT: begin
				if (cl >= DEPTH_WORD) begin
					r.cl = END_OF_CHAIN;
					r.st = STAT_NO_ENTRY;
				end else begin
					r.cl = next_link(cl);
				end
			end
			REQ_SET: begin
				if (cl >= DEPTH_WORD)
					r.st = STAT_NO_ENTRY;
				else
					link_mem[cl] = nv;
			end
			REQ_FREE: begin
				r.cl = END_OF_CHAIN;
				r.st = STAT_NO_ENTRY;
				for (k = FIRST_DATA_CLUSTER; in_data_area(k) && k < DEPTH_WORD; k++) begin
					if (link_mem[k] == '0) begin
						r.cl = k;
						r.st = STAT_OK;
						break;
					end
				end
			end
			default: begin
				hops = off >> log2_cfg;
				pos  = cl;
				k    = '0;
				while (k < hops) begin
					if (pos == END_OF_CHAIN) begin
						pos  = '0;
						r.st = STAT_SEEK_END;
						break;
					end
					if (pos < DEPTH_WORD) begin
						// back on a visited cluster: only hops modulo the loop length matter
						if (first_hop.exists(pos)) begin
							left = (hops - k) % (k - first_hop[pos]);
							while (left != 0) begin
								pos = next_link(pos);
								left--;
							end
							break;
						end
						first_hop[pos] = k;
					end
					pos = next_link(pos);
					k++;
				end
				r.cl = pos;
			end
		endcase
		return r;
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%t mismatch %s: expected %h, got %h", $realtime, what, want, got);
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_replies.size() == 0) begin
				note_mismatch("unexpected result beat", '0, m_tdata[31:0]);
			end else begin
				got_reply = awaited_replies.pop_front();
				if (m_tdata[31:0] !== got_reply.cl)
					note_mismatch("result_cluster", got_reply.cl, m_tdata[31:0]);
				if (m_tdata[33:32] !== got_reply.st)
					note_mismatch("status", 32'(got_reply.st), 32'(m_tdata[33:32]));
			end
		end
	end

	// called and returns at a falling edge
	task automatic issue(input req_t kind, input logic [31:0] cl, input logic [31:0] nv,
			input logic [31:0] off, input bit typed, input reply_t typed_reply);
		reply_t r;
		while ($urandom_range(99, 0) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {off, nv, cl};
		s_tuser  <= kind;
		do
			@(posedge clk);
		while (!s_tready);
		r = table_response(kind, cl, nv, off);
		if (typed)
			r = typed_reply;
		awaited_replies.push_back(r);
		@(negedge clk);
	endtask

	task automatic configure(input logic [11:0] count, input logic [4:0] size_log2);
		s_tvalid <= 1'b0;
		while (awaited_replies.size() != 0 || !s_tready)
			@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_CLUSTER_COUNT;
		cfg_data  <= count;
		@(negedge clk);
		cfg_index <= CFG_CLUSTER_LOG2;
		cfg_data  <= 12'(size_log2);
		@(negedge clk);
		cfg_we <= 1'b0;
		clusters_cfg = count;
		log2_cfg     = size_log2;
	endtask

	function automatic logic [31:0] pick_cluster();
		case ($urandom_range(15, 0))
			0: return $urandom();
			1: return 32'd4090 + 32'($urandom_range(11, 0));
			2: return 32'($urandom_range(1, 0));
			3: return END_OF_CHAIN;
			default: return FIRST_DATA_CLUSTER + 32'($urandom_range(clusters_cfg, 0));
		endcase
	endfunction

	function automatic logic [31:0] pick_link();
		case ($urandom_range(7, 0))
			0: return 32'd0;
			1: return $urandom();
			2: return END_OF_CHAIN;
			default: return FIRST_DATA_CLUSTER + 32'($urandom_range(clusters_cfg, 0));
		endcase
	endfunction

	// long walks kept rare: one item in 32 gets a full-range offset
	function automatic logic [31:0] pick_offset(input int n);
		logic [31:0] frac;
		frac = $urandom() & ((32'd1 << log2_cfg) - 32'd1);
		if (n % 32 == 7)
			return $urandom();
		return (32'($urandom_range(12, 0)) << log2_cfg) | frac;
	endfunction

	initial begin : stimulus
		reply_t      given;
		req_t        kind;
		int          p, i, sel;
		logic [31:0] cl;
		for (i = 0; i < TABLE_DEPTH; i++)
			link_mem[i] = '0;
		clusters_cfg  = CFG_COUNT_RST;
		log2_cfg      = CFG_LOG2_RST;
		mismatches    = 0;
		send_idle_pct = 33;
		recv_idle_pct = 77;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (probes[j]) begin
			given.cl = probes[j].want_cl;
			given.st = probes[j].want_st;
			issue(probes[j].kind, probes[j].cl, probes[j].nv, probes[j].off,
				probes[j].typed, given);
		end

		for (p = 0; p < 6; p++) begin
			case (p)
				0: configure(12'd0, 5'd20);
				1: configure(12'd4094, 5'd0);
				2: configure(12'd16, 5'($urandom_range(20, 0)));
				3: configure(12'($urandom_range(64, 1)), 5'($urandom_range(20, 0)));
				4: configure(12'd4, 5'd9);
				default: configure(12'($urandom_range(300, 0)), 5'($urandom_range(20, 0)));
			endcase
			case (p / 2)
				0: begin
					send_idle_pct = 33;
					recv_idle_pct = 77;
				end
				1: begin
					send_idle_pct = 77;
					recv_idle_pct = 33;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (i = 0; i < 105; i++) begin
				sel = $urandom_range(19, 0);
				if (sel < 4)
					kind = REQ_NEXT;
				else if (sel < 11)
					kind = REQ_SET;
				else if (sel < 14)
					kind = REQ_FREE;
				else
					kind = REQ_SEEK;
				cl = pick_cluster();
				issue(kind, cl, (kind == REQ_SET) ? pick_link() : $urandom(),
					(kind == REQ_SEEK) ? pick_offset(i) : $urandom(), 1'b0, given);
			end
		end

		s_tvalid <= 1'b0;
		while (awaited_replies.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: cluster_chain_table_engine.f
rtl/cct_pkg.sv
rtl/cct_ram.sv
rtl/cct_rem_div.sv
rtl/cct_ctrl.sv
rtl/cluster_chain_table_engine.sv
dv/cluster_chain_table_engine_tb.sv
